// File: hw/rtl/swerm_pkg.sv
// Shared types, constants and helpers of the sliding-window event rate meter.
package swerm_pkg;

    localparam int HIST_DEPTH = 128;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int STAMP_W    = 32;
    localparam int WIN_W      = 16;
    localparam int NFLAG      = 3;
    localparam int ENTRY_W    = STAMP_W + NFLAG;
    localparam int RATE_W     = 25;
    localparam int SCALE_W    = 18;
    localparam int PROD_W     = HIST_AW + SCALE_W;
    localparam int QUOT_W     = (PROD_W > RATE_W) ? PROD_W : RATE_W;
    localparam int DIV_CW     = $clog2(QUOT_W);

    localparam logic [SCALE_W-1:0] RATE_SCALE   = SCALE_W'(256000);
    localparam logic [RATE_W-1:0]  RATE_MAX     = '1;
    localparam logic [WIN_W-1:0]   WINDOW_RESET = WIN_W'(1000);

    // flag bit positions in a ring entry
    localparam int FLAG_VIRT  = 0;
    localparam int FLAG_DRAWN = 1;
    localparam int FLAG_BLIT  = 2;

    // configuration register indexes
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

    // which rate the shared divider works on
    typedef logic [1:0] t_sel;
    localparam t_sel SEL_VIRT  = 2'd0;
    localparam t_sel SEL_DRAWN = 2'd1;
    localparam t_sel SEL_BLIT  = 2'd2;

    typedef struct packed {
        logic accept;
        logic write_entry;
        logic scan_clear;
        logic scan_rd;
        logic span;
        logic div_start;
        logic div_store;
        t_sel div_sel;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic out_full;
        logic div_done;
    } t_stat;

    function automatic logic [HIST_AW-1:0] slot_next(input logic [HIST_AW-1:0] s);
        return (s == HIST_AW'(HIST_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

endpackage

// File: hw/rtl/swerm_div.sv
// Restoring divider, one quotient bit per cycle.
module swerm_div import swerm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [QUOT_W-1:0]  i_dividend,
    input  logic [STAMP_W-1:0] i_divisor,
    output logic               o_done,
    output logic [QUOT_W-1:0]  o_quot
);

    logic               r_busy;
    logic               r_done;
    logic [DIV_CW-1:0]  r_cnt;
    logic [STAMP_W-1:0] r_rem;
    logic [STAMP_W-1:0] r_dvs;
    logic [QUOT_W-1:0]  r_q;
    logic [STAMP_W:0]   w_trial;
    logic               w_ge;

    assign w_trial = {r_rem, r_q[QUOT_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(QUOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? STAMP_W'(w_trial - {1'b0, r_dvs}) : w_trial[STAMP_W-1:0];
            r_q   <= {r_q[QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: hw/rtl/swerm_datapath.sv
// History ring, window scan accumulators, rate division and output register.
module swerm_datapath import swerm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic               i_virtual_event,
    input  logic               i_drawn_event,
    input  logic               i_blitted_event,
    input  logic [STAMP_W-1:0] i_now_ms,
    input  logic [WIN_W-1:0]   i_window_ms,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [RATE_W-1:0]  o_virtual_rate,
    output logic [RATE_W-1:0]  o_drawn_rate,
    output logic [RATE_W-1:0]  o_blitted_rate,
    output logic               o_rate_valid
);

    logic [ENTRY_W-1:0] r_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] r_valid;
    logic [NFLAG-1:0]   r_pend;
    logic [HIST_AW-1:0] r_wslot;
    logic [HIST_AW-1:0] r_rd_ptr;
    logic               r_rd_en;
    logic [ENTRY_W-1:0] r_rd_word;
    logic               r_rd_live;
    logic [STAMP_W-1:0] r_now;
    logic [STAMP_W-1:0] r_low;
    logic [STAMP_W-1:0] r_start;
    logic               r_found;
    logic [HIST_AW-1:0] r_cnt [NFLAG];
    logic [STAMP_W-1:0] r_span;
    logic               r_ok;
    logic [RATE_W-1:0]  r_rate [NFLAG];
    logic               r_out_vld;
    logic [RATE_W-1:0]  r_o_virt;
    logic [RATE_W-1:0]  r_o_drawn;
    logic [RATE_W-1:0]  r_o_blit;
    logic               r_o_rv;

    logic [NFLAG-1:0]   w_flags;
    logic [STAMP_W-1:0] w_stamp;
    logic [NFLAG-1:0]   w_fl;
    logic               w_hit;
    logic [HIST_AW-1:0] w_cnt_sel;
    logic [PROD_W-1:0]  w_prod;
    logic               w_div_done;
    logic [QUOT_W-1:0]  w_quot;
    logic [RATE_W-1:0]  w_sat;

    assign w_flags = r_pend | {i_blitted_event, i_drawn_event, i_virtual_event};

    // pending mask, write slot, entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_wslot <= '0;
            r_valid <= '0;
        end else if (i_cmd.accept) begin
            if (i_cmd.write_entry) begin
                r_pend           <= '0;
                r_wslot          <= slot_next(r_wslot);
                r_valid[r_wslot] <= 1'b1;
            end else begin
                r_pend <= w_flags;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry) begin
            r_mem[r_wslot] <= {w_flags, i_now_ms};
        end
        r_rd_word <= r_mem[r_rd_ptr];
        r_rd_live <= r_valid[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_en  <= 1'b0;
            r_rd_ptr <= '0;
        end else begin
            r_rd_en <= i_cmd.scan_rd;
            if (i_cmd.scan_clear) begin
                r_rd_ptr <= slot_next(r_wslot);    // oldest entry after this write
            end else if (i_cmd.scan_rd) begin
                r_rd_ptr <= slot_next(r_rd_ptr);
            end
        end
    end

    // never-written slots read as zero
    assign w_stamp = r_rd_live ? r_rd_word[STAMP_W-1:0] : '0;
    assign w_fl    = r_rd_live ? r_rd_word[ENTRY_W-1:STAMP_W] : '0;
    assign w_hit   = w_stamp >= r_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.scan_clear) begin
            r_found <= 1'b0;
        end else if (r_rd_en && w_hit) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_clear) begin
            r_now   <= i_now_ms;
            r_low   <= i_now_ms - STAMP_W'(i_window_ms);
            r_start <= '0;
            for (int k = 0; k < NFLAG; k++) begin
                r_cnt[k] <= '0;
            end
        end else if (r_rd_en && w_hit) begin
            if (r_found) begin
                // first in-window entry opens the window, later ones count
                for (int k = 0; k < NFLAG; k++) begin
                    r_cnt[k] <= r_cnt[k] + HIST_AW'(w_fl[k]);
                end
                if (w_stamp < r_start) begin
                    r_start <= w_stamp;
                end
            end else begin
                r_start <= w_stamp;
            end
        end
        if (i_cmd.span) begin
            r_span <= r_now - r_start;
            r_ok   <= r_found && (r_now > r_start);
        end
    end

    always_comb begin
        case (i_cmd.div_sel)
            SEL_VIRT:  w_cnt_sel = r_cnt[FLAG_VIRT];
            SEL_DRAWN: w_cnt_sel = r_cnt[FLAG_DRAWN];
            default:   w_cnt_sel = r_cnt[FLAG_BLIT];
        endcase
    end

    assign w_prod = PROD_W'(w_cnt_sel) * PROD_W'(RATE_SCALE);

    swerm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (QUOT_W'(w_prod)),
        .i_divisor  (r_span),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_sat = (w_quot > QUOT_W'(RATE_MAX)) ? RATE_MAX : w_quot[RATE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_store) begin
            case (i_cmd.div_sel)
                SEL_VIRT:  r_rate[FLAG_VIRT]  <= w_sat;
                SEL_DRAWN: r_rate[FLAG_DRAWN] <= w_sat;
                default:   r_rate[FLAG_BLIT]  <= w_sat;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_virt  <= r_ok ? r_rate[FLAG_VIRT]  : '0;
            r_o_drawn <= r_ok ? r_rate[FLAG_DRAWN] : '0;
            r_o_blit  <= r_ok ? r_rate[FLAG_BLIT]  : '0;
            r_o_rv    <= r_ok;
        end
    end

    assign o_stat.out_full = r_out_vld;
    assign o_stat.div_done = w_div_done;
    assign o_out_valid     = r_out_vld;
    assign o_virtual_rate  = r_o_virt;
    assign o_drawn_rate    = r_o_drawn;
    assign o_blitted_rate  = r_o_blit;
    assign o_rate_valid    = r_o_rv;

endmodule

// File: hw/rtl/swerm_ctrl.sv
// Sequencer: intake, ring scan, three divisions, result hand-off.
module swerm_ctrl import swerm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  logic  i_frame_end,
    input  logic  i_active,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output logic  o_ready,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_SPAN,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } t_state;

    t_state             r_state, n_state;
    logic [HIST_AW-1:0] r_cnt, n_cnt;
    t_sel               r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.div_sel = r_sel;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_valid;
                if (i_valid && i_frame_end) begin
                    o_cmd.write_entry = 1'b1;
                    if (i_active) begin
                        o_cmd.scan_clear = 1'b1;
                        n_cnt   = '0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == HIST_AW'(HIST_DEPTH - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_SPAN;
            end
            ST_SPAN: begin
                o_cmd.span = 1'b1;
                n_sel   = SEL_VIRT;
                n_state = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.div_store = 1'b1;
                    if (r_sel == SEL_BLIT) begin
                        n_state = ST_OUT;
                    end else begin
                        n_sel   = r_sel + 1'b1;
                        n_state = ST_DIV_GO;
                    end
                end
            end
            ST_OUT: begin
                if (!i_stat.out_full || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_sel   <= SEL_VIRT;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

endmodule

// File: hw/rtl/sliding_window_event_rate_meter_unit.sv
// Top level of the sliding-window event rate meter.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_virtual_event, i_drawn_event,
//                                            i_blitted_event, i_frame_end, i_now_ms
//  result    out        o_valid / i_ready    o_virtual_rate, o_drawn_rate,
//                                            o_blitted_rate, o_rate_valid
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_wdata
//
// An item without frame end, or a frame end while not active, is taken at once.
// A frame end while active passes through scan, drain, span, divisions and hand-off:
// the ring scan reads one entry per cycle through the single ring read port,
// then one shared restoring divider produces the three rates at 1 bit/cycle.
// Reset (synchronous) clears all entry valid bits together; no clear pass.
// A result waits in the output register; a stalled consumer holds the block
// only when the next result is ready to load.
module sliding_window_event_rate_meter_unit import swerm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_virtual_event,
    input  logic                 i_drawn_event,
    input  logic                 i_blitted_event,
    input  logic                 i_frame_end,
    input  logic [STAMP_W-1:0]   i_now_ms,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [RATE_W-1:0]    o_virtual_rate,
    output logic [RATE_W-1:0]    o_drawn_rate,
    output logic [RATE_W-1:0]    o_blitted_rate,
    output logic                 o_rate_valid,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    logic             r_active;
    logic [WIN_W-1:0] r_window;
    t_cmd             w_cmd;
    t_stat            w_stat;

    // configuration registers; the user is to write them only while the block is idle; the block has no guard for this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ACTIVE: r_active <= i_cfg_wdata[0];
                CFG_WINDOW: r_window <= i_cfg_wdata[WIN_W-1:0];
                default:    r_active <= r_active;
            endcase
        end
    end

    swerm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_frame_end (i_frame_end),
        .i_active    (r_active),
        .i_out_ready (i_ready),
        .i_stat      (w_stat),
        .o_ready     (o_ready),
        .o_cmd       (w_cmd)
    );

    swerm_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_virtual_event (i_virtual_event),
        .i_drawn_event   (i_drawn_event),
        .i_blitted_event (i_blitted_event),
        .i_now_ms        (i_now_ms),
        .i_window_ms     (r_window),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_virtual_rate  (o_virtual_rate),
        .o_drawn_rate    (o_drawn_rate),
        .o_blitted_rate  (o_blitted_rate),
        .o_rate_valid    (o_rate_valid)
    );

endmodule

// File: hw/rtl/swerm_checker.sv
// Port-level checks of the rate meter, bound to the top level.
module swerm_checker import swerm_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 o_ready,
    input logic                 i_frame_end,
    input logic                 o_valid,
    input logic                 i_ready,
    input logic [RATE_W-1:0]    o_virtual_rate,
    input logic [RATE_W-1:0]    o_drawn_rate,
    input logic [RATE_W-1:0]    o_blitted_rate,
    input logic                 o_rate_valid
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result present after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_virtual_rate) &&
            $stable(o_drawn_rate) && $stable(o_blitted_rate) && $stable(o_rate_valid))
        else $error("stalled result changed");

    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rate_valid |-> o_virtual_rate == '0 && o_drawn_rate == '0 &&
            o_blitted_rate == '0)
        else $error("nonzero rate without rate_valid");

    a_plain_item_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_frame_end |=> o_ready)
        else $error("item without frame end stalled intake");

endmodule

bind sliding_window_event_rate_meter_unit swerm_checker u_chk (.*);

// File: bench/event_rate_checker.sv
`timescale 1ns / 1ps
// Channel monitor, rate predictor and result comparison for the rate meter.
module event_rate_checker import swerm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_virtual_event,
    input  logic                 i_drawn_event,
    input  logic                 i_blitted_event,
    input  logic                 i_frame_end,
    input  logic [STAMP_W-1:0]   i_now_ms,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [RATE_W-1:0]    i_virtual_rate,
    input  logic [RATE_W-1:0]    i_drawn_rate,
    input  logic [RATE_W-1:0]    i_blitted_rate,
    input  logic                 i_rate_valid,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output int unsigned          o_fail_count,
    output int unsigned          o_pending
);

    typedef struct packed {
        logic [RATE_W-1:0] virt;
        logic [RATE_W-1:0] drawn;
        logic [RATE_W-1:0] blit;
        logic              valid;
    } t_rate_set;

    // shadow of the meter state
    logic [STAMP_W-1:0] stamp_hist [HIST_DEPTH];
    logic [NFLAG-1:0]   flag_hist  [HIST_DEPTH];
    logic [HIST_AW-1:0] next_slot;
    logic [NFLAG-1:0]   flags_seen;
    logic               meter_on;
    logic [WIN_W-1:0]   window_len;

    t_rate_set   expected_rates [$];
    int unsigned fail_total    = 0;
    int unsigned pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    function automatic logic [RATE_W-1:0] scaled_rate(input int unsigned hits,
                                                      input logic [STAMP_W-1:0] span);
        longint unsigned q;
        q = (64'(hits) * 64'(RATE_SCALE)) / 64'(span);
        return (q > 64'(RATE_MAX)) ? RATE_MAX : RATE_W'(q);
    endfunction

    // Writes the frame into history; returns 1 with the rates when reporting.
    function automatic bit log_frame(input logic [STAMP_W-1:0] now, output t_rate_set rates);
        logic [STAMP_W-1:0] low;
        logic [STAMP_W-1:0] start;
        logic [STAMP_W-1:0] span;
        logic [HIST_AW-1:0] q;
        int unsigned        hits [NFLAG];
        bit                 opened;
        stamp_hist[next_slot] = now;
        flag_hist[next_slot]  = flags_seen;
        next_slot  = (next_slot == HIST_AW'(HIST_DEPTH - 1)) ? '0 : next_slot + 1'b1;
        flags_seen = '0;
        rates      = '0;
        if (!meter_on)
            return 1'b0;
        low    = now - STAMP_W'(window_len);
        start  = '0;
        opened = 1'b0;
        for (int f = 0; f < NFLAG; f++)
            hits[f] = 0;
        // oldest to newest; the first hit opens the window and is not counted
        for (int i = 0; i < HIST_DEPTH; i++) begin
            q = HIST_AW'((int'(next_slot) + i) % HIST_DEPTH);
            if (stamp_hist[q] >= low) begin
                if (opened) begin
                    for (int f = 0; f < NFLAG; f++)
                        if (flag_hist[q][f])
                            hits[f]++;
                    if (stamp_hist[q] < start)
                        start = stamp_hist[q];
                end else begin
                    start  = stamp_hist[q];
                    opened = 1'b1;
                end
            end
        end
        if (opened && now > start) begin
            span        = now - start;
            rates.virt  = scaled_rate(hits[FLAG_VIRT], span);
            rates.drawn = scaled_rate(hits[FLAG_DRAWN], span);
            rates.blit  = scaled_rate(hits[FLAG_BLIT], span);
            rates.valid = 1'b1;
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string field, input logic [RATE_W-1:0] want,
                                        input logic [RATE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_rate_set got;
        t_rate_set want;
        t_rate_set fresh;
        if (!i_rst_n) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                stamp_hist[i] = '0;
                flag_hist[i]  = '0;
            end
            next_slot  = '0;
            flags_seen = '0;
            meter_on   = 1'b0;
            window_len = WINDOW_RESET;
            expected_rates.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACTIVE: meter_on   = i_cfg_wdata[0];
                    CFG_WINDOW: window_len = i_cfg_wdata[WIN_W-1:0];
                    default: ;
                endcase
            end
            // results first: one leaving now cannot come from an item entering now
            if (i_out_valid && i_out_ready) begin
                got = '{virt: i_virtual_rate, drawn: i_drawn_rate, blit: i_blitted_rate,
                        valid: i_rate_valid};
                if (expected_rates.size() == 0) begin
                    $display("%0t: result with none expected: %0d %0d %0d valid %0d",
                             $time, got.virt, got.drawn, got.blit, got.valid);
                    fail_total++;
                end else begin
                    want = expected_rates.pop_front();
                    check_field("virtual_rate", want.virt, got.virt);
                    check_field("drawn_rate", want.drawn, got.drawn);
                    check_field("blitted_rate", want.blit, got.blit);
                    check_field("rate_valid", want.valid, got.valid);
                end
            end
            if (i_in_valid && i_in_ready) begin
                flags_seen[FLAG_VIRT]  = flags_seen[FLAG_VIRT]  | i_virtual_event;
                flags_seen[FLAG_DRAWN] = flags_seen[FLAG_DRAWN] | i_drawn_event;
                flags_seen[FLAG_BLIT]  = flags_seen[FLAG_BLIT]  | i_blitted_event;
                if (i_frame_end && log_frame(i_now_ms, fresh))
                    expected_rates.push_back(fresh);
            end
        end
        pending_total = expected_rates.size();
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Bench top for the rate meter: clock, reset, item stimulus, stalls and verdict.
module tb;
    import swerm_pkg::*;

    localparam int PHASE_COUNT     = 6;
    localparam int ITEMS_PER_PHASE = 200;
    // drain time: longer than the work of one frame end while active
    localparam int DRAIN_CYCLES    = 240;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_valid         = 1'b0;
    logic                 o_ready;
    logic                 i_virtual_event = 1'b0;
    logic                 i_drawn_event   = 1'b0;
    logic                 i_blitted_event = 1'b0;
    logic                 i_frame_end     = 1'b0;
    logic [STAMP_W-1:0]   i_now_ms        = '0;
    logic                 o_valid;
    logic                 i_ready         = 1'b1;
    logic [RATE_W-1:0]    o_virtual_rate;
    logic [RATE_W-1:0]    o_drawn_rate;
    logic [RATE_W-1:0]    o_blitted_rate;
    logic                 o_rate_valid;
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx       = CFG_ACTIVE;
    logic [CFG_W-1:0]     i_cfg_wdata     = '0;

    int unsigned fail_total;
    int unsigned pending_results;

    // receiver stall control
    logic rx_idle_en = 1'b0;
    int   stall_left = 0;

    always #1 i_clk = ~i_clk;

    sliding_window_event_rate_meter_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_virtual_event (i_virtual_event),
        .i_drawn_event   (i_drawn_event),
        .i_blitted_event (i_blitted_event),
        .i_frame_end     (i_frame_end),
        .i_now_ms        (i_now_ms),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_virtual_rate  (o_virtual_rate),
        .o_drawn_rate    (o_drawn_rate),
        .o_blitted_rate  (o_blitted_rate),
        .o_rate_valid    (o_rate_valid),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    event_rate_checker rate_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_virtual_event (i_virtual_event),
        .i_drawn_event   (i_drawn_event),
        .i_blitted_event (i_blitted_event),
        .i_frame_end     (i_frame_end),
        .i_now_ms        (i_now_ms),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_virtual_rate  (o_virtual_rate),
        .i_drawn_rate    (o_drawn_rate),
        .i_blitted_rate  (o_blitted_rate),
        .i_rate_valid    (o_rate_valid),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_fail_count    (fail_total),
        .o_pending       (pending_results)
    );

    // Result-side back-pressure: random stall bursts while enabled.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 10);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Presents one item and returns at the edge where it is taken. Called at a
    // rising edge; valid stays up with the payload frozen until o_ready.
    task automatic push_item(input logic [NFLAG-1:0] flags, input logic fe,
                             input logic [STAMP_W-1:0] now);
        i_valid         <= 1'b1;
        i_virtual_event <= flags[FLAG_VIRT];
        i_drawn_event   <= flags[FLAG_DRAWN];
        i_blitted_event <= flags[FLAG_BLIT];
        i_frame_end     <= fe;
        i_now_ms        <= now;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
    endtask

    // Register write; the trailing edge keeps back-to-back writes apart.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid, wait for every expected result, then let the block go quiet.
    // The first edge lets the checker log the item taken at this edge.
    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Hard stop: far beyond the slowest legal run (every item a frame end with
    // full stalls on both sides).
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        logic [NFLAG-1:0]   flags;
        logic               fe;
        logic [STAMP_W-1:0] now;
        logic [STAMP_W-1:0] clock_ms;
        logic [WIN_W-1:0]   win_len;
        int unsigned        step_max;
        int unsigned        roll;
        bit                 tx_idle_en;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // Out of reset the meter is off: flags collect, a frame end is recorded
        // but nothing comes back.
        push_item(3'b001, 1'b0, $urandom);
        push_item(3'b010, 1'b1, 32'd100);
        settle();
        // switch on, window left at its reset length of 1000 ms
        write_reg(CFG_ACTIVE, CFG_W'(1));
        // now equal to the window: never-written zero stamps fall in range
        push_item(3'b000, 1'b1, 32'd1000);
        // now below the window: the low bound wraps, nothing is in range
        push_item(3'b000, 1'b1, 32'd999);
        // only its own entry in range, start equals now
        push_item(3'b111, 1'b1, 32'd50000);
        // flags of a plain item land in the next frame's entry
        push_item(3'b100, 1'b0, $urandom);
        push_item(3'b000, 1'b1, 32'd50016);
        push_item(3'b111, 1'b1, 32'd50033);
        push_item(3'b011, 1'b1, 32'd50050);
        push_item(3'b101, 1'b1, 32'd50066);
        // timestamp is ignored without a frame end
        push_item(3'b110, 1'b0, 32'hFFFF_FFFF);
        // top of the time range, then wrap to zero: start lies above now
        push_item(3'b111, 1'b1, 32'hFFFF_FFFF);
        push_item(3'b111, 1'b1, 32'd0);
        push_item(3'b010, 1'b1, 32'd500);
        // time steps back
        push_item(3'b111, 1'b1, 32'd50050);
        settle();
        // shortest window: repeated stamp gives a zero span, then a 1 ms span
        write_reg(CFG_WINDOW, CFG_W'(1));
        push_item(3'b111, 1'b1, 32'd60000);
        push_item(3'b111, 1'b1, 32'd60000);
        push_item(3'b111, 1'b1, 32'd60001);
        settle();
        // longest window
        write_reg(CFG_WINDOW, CFG_W'(65535));
        push_item(3'b111, 1'b1, 32'd130000);
        push_item(3'b011, 1'b1, 32'd195535);
        push_item(3'b101, 1'b1, 32'd195600);

        // ---- random part ----
        // Mostly a running clock with small steps so the ring fills with
        // in-range entries; the rest is stray stamps, steps back in time and
        // jumps near the top of the range that then wrap.
        clock_ms = 32'd200000;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            settle();
            case (p)
                0:       win_len = WIN_W'($urandom_range(100, 2000));
                1:       win_len = WIN_W'(300);
                2:       win_len = WIN_W'(65535);
                3:       win_len = WIN_W'(1);
                4:       win_len = WIN_W'($urandom_range(1, 65535));
                default: win_len = WIN_W'(1000);
            endcase
            // phase 1 only records history
            write_reg(CFG_ACTIVE, CFG_W'(p != 1));
            write_reg(CFG_WINDOW, CFG_W'(win_len));
            step_max = win_len / 16 + 2;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // idling comes and goes in stretches; the last phase runs flat out
                if (n % 40 == 0) begin
                    tx_idle_en = (p != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
                    rx_idle_en <= (p != PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
                end
                flags = NFLAG'($urandom);
                fe    = ($urandom_range(0, 99) < 40);
                now   = $urandom;
                roll  = $urandom_range(0, 99);
                if (fe) begin
                    if (roll < 85) begin
                        clock_ms = clock_ms + STAMP_W'($urandom_range(0, step_max));
                        now      = clock_ms;
                    end else if (roll < 95) begin
                        now = (roll < 90) ? $urandom
                                          : clock_ms - STAMP_W'($urandom_range(0, 2 * win_len));
                    end else begin
                        clock_ms = 32'hFFFF_FFFF - STAMP_W'($urandom_range(0, 4 * win_len));
                        now      = clock_ms;
                    end
                end
                if (tx_idle_en && $urandom_range(0, 4) == 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 11)) @(posedge i_clk);
                end
                push_item(flags, fe, now);
            end
        end

        settle();
        if (fail_total == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sliding_window_event_rate_meter_unit.f
hw/rtl/swerm_pkg.sv
hw/rtl/swerm_div.sv
hw/rtl/swerm_datapath.sv
hw/rtl/swerm_ctrl.sv
hw/rtl/sliding_window_event_rate_meter_unit.sv
hw/rtl/swerm_checker.sv
bench/event_rate_checker.sv
bench/tb.sv
